@@ rtl/core/dte_pkg.sv @@
// ----------------------------------------------------------------------------
// dte_pkg
// Shared types, constants and helpers for the date-time to epoch converter.
// ----------------------------------------------------------------------------
package dte_pkg;

    // one classified date-time word, passed from the front end to the back end
    typedef struct packed {
        logic              ok;         // calendar date is valid
        logic signed [15:0] year;
        logic [3:0]        month;      // 1..12 when ok
        logic [4:0]        day;        // 1..31 when ok
        logic signed [7:0] hz;         // hour minus zone offset
        logic [5:0]        minute;
        logic [15:0]       second_ms;
    } dte_item_t;

    localparam int MONTH_MAX = 12;

    // floor division by 25 of a small non-negative value: (t * 41944) >> 20,
    // exact for t below 43690
    localparam logic [15:0] DIV25_MUL   = 16'd41944;
    localparam int          DIV25_SHIFT = 20;
    localparam int          Q25_W       = 10;

    // biases that make year / 4 and year / 16 non-negative before dividing by 25;
    // both are multiples of 25 so the floor can be corrected afterwards
    localparam int DIV100_OFFSET = 8200;
    localparam int DIV400_OFFSET = 2050;
    localparam int DIV100_BIAS   = DIV100_OFFSET / 25;
    localparam int DIV400_BIAS   = DIV400_OFFSET / 25;

    function automatic logic [30:0] mul_div25(input logic [14:0] t);
        return 31'(t) * 31'(DIV25_MUL);
    endfunction

endpackage

@@ rtl/core/dte_front.sv @@
// ----------------------------------------------------------------------------
// dte_front
// Input register stage: clamps absent fields, folds the zone into the hour
// and checks the calendar date, including leap years.
// ----------------------------------------------------------------------------
module dte_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  logic signed [15:0] year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    input  logic signed [5:0]  hour,
    input  logic [5:0]         minute,
    input  logic [15:0]        second_ms,
    input  logic signed [5:0]  zone_hours,
    output logic               item_valid,
    output dte_pkg::dte_item_t item,
    input  logic               item_stall
);
    import dte_pkg::*;

    localparam logic signed [15:0] YEAR_OUT_OF_RANGE = 16'sh8000;

    logic      v_reg;
    logic      v_next;
    dte_item_t item_reg;
    dte_item_t item_next;
    logic      load;

    logic [3:0]        month_c;
    logic [4:0]        day_c;
    logic [4:0]        hour_c;
    logic signed [7:0] hour_w;
    logic signed [7:0] zone_w;
    logic              leap;
    logic [4:0]        mlen;

    function automatic logic is_leap(input logic signed [15:0] y);
        logic signed [15:0] y4;
        logic signed [15:0] y16;
        logic [14:0]        t100;
        logic [14:0]        t400;
        logic [30:0]        p100;
        logic [30:0]        p400;
        logic [Q25_W-1:0]   q100;
        logic [Q25_W-1:0]   q400;
        logic               div100;
        logic               div400;
        y4     = y >>> 2;
        y16    = y >>> 4;
        t100   = 15'(y4 + 16'(DIV100_OFFSET));
        t400   = 15'(y16 + 16'(DIV400_OFFSET));
        p100   = mul_div25(t100);
        p400   = mul_div25(t400);
        q100   = p100[DIV25_SHIFT +: Q25_W];
        q400   = p400[DIV25_SHIFT +: Q25_W];
        // with year divisible by 4, year % 100 == 0 iff (year / 4) % 25 == 0
        div100 = (15'(q100) * 15'd25) == t100;
        div400 = (y[3:0] == 4'd0) && ((15'(q400) * 15'd25) == t400);
        return (y[1:0] == 2'b00) && (!div100 || div400);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
        logic [4:0] len;
        case (m)
            4'd2:    len = lp ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    assign stall      = v_reg && item_stall;
    assign load       = !v_reg || !item_stall;
    assign item_valid = v_reg;
    assign item       = item_reg;

    always_comb
    begin
        month_c = (month == 4'd0) ? 4'd1 : month;
        day_c   = (day == 5'd0) ? 5'd1 : day;
        hour_c  = hour[5] ? 5'd0 : hour[4:0];
        hour_w  = signed'({3'b000, hour_c});
        zone_w  = 8'(zone_hours);
        leap    = is_leap(year);
        mlen    = month_len(month_c, leap);

        item_next.ok        = (year != YEAR_OUT_OF_RANGE)
                              && (month_c <= 4'(MONTH_MAX))
                              && (day_c <= mlen);
        item_next.year      = year;
        item_next.month     = month_c;
        item_next.day       = day_c;
        item_next.hz        = hour_w - zone_w;
        item_next.minute    = minute;
        item_next.second_ms = second_ms;
    end

    always_comb
    begin
        v_next = v_reg;
        if (load)
        begin
            v_next = valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/core/dte_fifo.sv @@
// ----------------------------------------------------------------------------
// dte_fifo
// Short queue of classified words between the front end and the back end.
// ----------------------------------------------------------------------------
module dte_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_stall,
    input  dte_pkg::dte_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_stall,
    output dte_pkg::dte_item_t pop_item
);
    import dte_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dte_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W-1:0] rd_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             full;
    logic             push;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = cnt_reg == CNT_W'(DEPTH);
    assign push_stall = full;
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && !full;
    assign pop        = pop_valid && !pop_stall;
    assign pop_item   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ptr_inc(wr_reg) : wr_reg;
        rd_next  = pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (wr_reg == rd_reg))
        else $error("full queue with unequal pointers");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_reg == rd_reg))
        else $error("empty queue with unequal pointers");

endmodule

@@ rtl/core/dte_back.sv @@
// ----------------------------------------------------------------------------
// dte_back
// Four-stage arithmetic pipeline: day count from the civil date, seconds of
// the day, whole seconds since the epoch, then milliseconds and the result.
// ----------------------------------------------------------------------------
module dte_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  dte_pkg::dte_item_t item,
    output logic               item_stall,
    output logic               res_valid,
    input  logic               res_stall,
    output logic               valid_res,
    output logic signed [50:0] epoch_ms,
    output logic signed [41:0] epoch_seconds
);
    import dte_pkg::*;

    localparam int          DAYS_TO_EPOCH = 719468;
    localparam int          SEC_PER_DAY   = 86400;
    localparam int          SEC_PER_HOUR  = 3600;
    localparam int          SEC_PER_MIN   = 60;
    localparam int          MS_PER_SEC    = 1000;
    // floor(ms / 1000) for a 16-bit value: (ms * 67109) >> 26
    localparam logic [16:0] SEC_DIV_MUL   = 17'd67109;
    localparam int          SEC_DIV_SHIFT = 26;

    // stage enables, back to front
    logic en1;
    logic en2;
    logic en3;
    logic en4;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic v4_reg, v4_next;

    // stage 1
    logic               s1_ok_reg, s1_ok_next;
    logic signed [16:0] s1_yy_reg, s1_yy_next;
    logic [30:0]        s1_p100_reg, s1_p100_next;
    logic [30:0]        s1_p400_reg, s1_p400_next;
    logic [8:0]         s1_doyd_reg, s1_doyd_next;
    logic signed [7:0]  s1_hz_reg, s1_hz_next;
    logic [5:0]         s1_minute_reg, s1_minute_next;
    logic [15:0]        s1_sec_reg, s1_sec_next;
    logic [32:0]        s1_psec_reg, s1_psec_next;

    // stage 2
    logic               s2_ok_reg, s2_ok_next;
    logic signed [24:0] s2_days_reg, s2_days_next;
    logic signed [18:0] s2_stod_reg, s2_stod_next;
    logic [9:0]         s2_rt_reg, s2_rt_next;

    // stage 3
    logic               s3_ok_reg, s3_ok_next;
    logic signed [41:0] s3_f_reg, s3_f_next;
    logic [9:0]         s3_rt_reg, s3_rt_next;

    // stage 4, output register
    logic               s4_ok_reg, s4_ok_next;
    logic signed [50:0] s4_ms_reg, s4_ms_next;
    logic signed [41:0] s4_sec_reg, s4_sec_next;

    // stage 1 locals
    logic signed [16:0] yy;
    logic signed [16:0] q4;
    logic signed [16:0] q16;

    // stage 2 locals
    logic [Q25_W-1:0]   q100;
    logic [Q25_W-1:0]   q400;
    logic [6:0]         qsec;
    logic signed [31:0] yy_w;
    logic signed [31:0] days_w;
    logic signed [31:0] stod_w;
    logic [16:0]        rt_w;

    // stage 4 locals
    logic signed [50:0] ms_w;
    logic signed [41:0] sec_w;

    // day of the March-based year on which the month starts
    function automatic logic [8:0] doy_of(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd306;
            4'd2:    d = 9'd337;
            4'd3:    d = 9'd0;
            4'd4:    d = 9'd31;
            4'd5:    d = 9'd61;
            4'd6:    d = 9'd92;
            4'd7:    d = 9'd122;
            4'd8:    d = 9'd153;
            4'd9:    d = 9'd184;
            4'd10:   d = 9'd214;
            4'd11:   d = 9'd245;
            4'd12:   d = 9'd275;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    assign en4        = !v4_reg || !res_stall;
    assign en3        = !v3_reg || en4;
    assign en2        = !v2_reg || en3;
    assign en1        = !v1_reg || en2;
    assign item_stall = !en1;

    assign res_valid     = v4_reg;
    assign valid_res     = s4_ok_reg;
    assign epoch_ms      = s4_ms_reg;
    assign epoch_seconds = s4_sec_reg;

    always_comb
    begin
        v1_next = en1 ? item_valid : v1_reg;
        v2_next = en2 ? v1_reg : v2_reg;
        v3_next = en3 ? v2_reg : v3_reg;
        v4_next = en4 ? v3_reg : v4_reg;
    end

    // stage 1: March-based year and the two divide-by-25 products
    always_comb
    begin
        yy  = 17'(item.year) - ((item.month <= 4'd2) ? 17'sd1 : 17'sd0);
        q4  = yy >>> 2;
        q16 = yy >>> 4;

        s1_ok_next     = item.ok;
        s1_yy_next     = yy;
        s1_p100_next   = mul_div25(15'(q4 + 17'(DIV100_OFFSET)));
        s1_p400_next   = mul_div25(15'(q16 + 17'(DIV400_OFFSET)));
        s1_doyd_next   = doy_of(item.month) + 9'(item.day) - 9'd1;
        s1_hz_next     = item.hz;
        s1_minute_next = item.minute;
        s1_sec_next    = item.second_ms;
        s1_psec_next   = 33'(item.second_ms) * 33'(SEC_DIV_MUL);
    end

    // stage 2: day number and seconds of the day, ms remainder split off
    always_comb
    begin
        q100 = s1_p100_reg[DIV25_SHIFT +: Q25_W];
        q400 = s1_p400_reg[DIV25_SHIFT +: Q25_W];
        qsec = s1_psec_reg[SEC_DIV_SHIFT +: 7];
        yy_w = 32'(s1_yy_reg);

        // 365*y + y/4 - y/100 + y/400, all floored
        days_w = yy_w * 32'sd365 + (yy_w >>> 2)
               - (signed'({22'd0, q100}) - 32'(DIV100_BIAS))
               + (signed'({22'd0, q400}) - 32'(DIV400_BIAS))
               + signed'({23'd0, s1_doyd_reg})
               - 32'(DAYS_TO_EPOCH);

        stod_w = 32'(s1_hz_reg) * 32'(SEC_PER_HOUR)
               + signed'({26'd0, s1_minute_reg}) * 32'(SEC_PER_MIN)
               + signed'({25'd0, qsec});

        rt_w = 17'(s1_sec_reg) - 17'(qsec) * 17'(MS_PER_SEC);

        s2_ok_next   = s1_ok_reg;
        s2_days_next = days_w[24:0];
        s2_stod_next = stod_w[18:0];
        s2_rt_next   = rt_w[9:0];
    end

    // stage 3: floored seconds since the epoch
    always_comb
    begin
        s3_ok_next = s2_ok_reg;
        s3_f_next  = 42'(s2_days_reg) * 42'(SEC_PER_DAY) + 42'(s2_stod_reg);
        s3_rt_next = s2_rt_reg;
    end

    // stage 4: milliseconds, and seconds rounded toward zero
    always_comb
    begin
        ms_w  = 51'(s3_f_reg) * 51'(MS_PER_SEC) + signed'(51'(s3_rt_reg));
        sec_w = s3_f_reg + ((s3_f_reg[41] && (s3_rt_reg != '0)) ? 42'sd1 : 42'sd0);

        s4_ok_next  = s3_ok_reg;
        s4_ms_next  = s3_ok_reg ? ms_w : '0;
        s4_sec_next = s3_ok_reg ? sec_w : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_ok_reg     <= s1_ok_next;
            s1_yy_reg     <= s1_yy_next;
            s1_p100_reg   <= s1_p100_next;
            s1_p400_reg   <= s1_p400_next;
            s1_doyd_reg   <= s1_doyd_next;
            s1_hz_reg     <= s1_hz_next;
            s1_minute_reg <= s1_minute_next;
            s1_sec_reg    <= s1_sec_next;
            s1_psec_reg   <= s1_psec_next;
        end
        if (en2)
        begin
            s2_ok_reg   <= s2_ok_next;
            s2_days_reg <= s2_days_next;
            s2_stod_reg <= s2_stod_next;
            s2_rt_reg   <= s2_rt_next;
        end
        if (en3)
        begin
            s3_ok_reg <= s3_ok_next;
            s3_f_reg  <= s3_f_next;
            s3_rt_reg <= s3_rt_next;
        end
        if (en4)
        begin
            s4_ok_reg  <= s4_ok_next;
            s4_ms_reg  <= s4_ms_next;
            s4_sec_reg <= s4_sec_next;
        end
    end

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !s4_ok_reg) |-> ((s4_ms_reg == '0) && (s4_sec_reg == '0)))
        else $error("invalid date with nonzero result");

    a_sign_match: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && s4_ok_reg && s4_ms_reg[50]) |-> (s4_sec_reg <= 42'sd0))
        else $error("negative ms with positive seconds");

endmodule

@@ rtl/core/datetime_to_epoch_ms_unit.sv @@
// ----------------------------------------------------------------------------
// datetime_to_epoch_ms_unit
// Converts a proleptic Gregorian date-time with a whole-hour zone offset to
// UTC milliseconds and whole seconds since 1970-01-01. Takes one word per
// cycle while the result side does not stall. An accepted word loads the
// input classifier, moves on into the queue and then passes through the four
// arithmetic stages, the last of which is the output register. The widest step
// is the floored seconds count times 1000. While the result side is stalled the
// unit holds FIFO_DEPTH plus five words (classifier, queue and the four stages)
// before it stalls its input. A month or day of 0 reads as 1, a negative hour
// as 0; an impossible date gives valid_res 0 and zero results. Seconds are
// rounded toward zero.
// ----------------------------------------------------------------------------
module datetime_to_epoch_ms_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               date_valid,
    output logic               date_stall,
    input  logic signed [15:0] year,
    input  logic [3:0]         month,
    input  logic [4:0]         day,
    input  logic signed [5:0]  hour,
    input  logic [5:0]         minute,
    input  logic [15:0]        second_ms,
    input  logic signed [5:0]  zone_hours,
    output logic               epoch_valid,
    input  logic               epoch_stall,
    output logic               valid_res,
    output logic signed [50:0] epoch_ms,
    output logic signed [41:0] epoch_seconds
);
    import dte_pkg::*;

    logic      front_valid;
    logic      front_stall;
    dte_item_t front_item;
    logic      queue_valid;
    logic      queue_stall;
    dte_item_t queue_item;

    dte_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (date_valid),
        .stall      (date_stall),
        .year       (year),
        .month      (month),
        .day        (day),
        .hour       (hour),
        .minute     (minute),
        .second_ms  (second_ms),
        .zone_hours (zone_hours),
        .item_valid (front_valid),
        .item       (front_item),
        .item_stall (front_stall)
    );

    dte_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_stall (front_stall),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_stall  (queue_stall),
        .pop_item   (queue_item)
    );

    dte_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (queue_valid),
        .item          (queue_item),
        .item_stall    (queue_stall),
        .res_valid     (epoch_valid),
        .res_stall     (epoch_stall),
        .valid_res     (valid_res),
        .epoch_ms      (epoch_ms),
        .epoch_seconds (epoch_seconds)
    );

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb - testbench for datetime_to_epoch_ms_unit
// Drives calendar date-time words into the converter and checks every epoch
// word against a civil-to-days calculation of its own or a directed value. A short
// directed table covers extremes, absent fields and impossible dates, then
// well-formed, broken and noise words run under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_HALF      = 4;
    localparam int     RESET_CYCLES  = 5;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam int     HOLD_CYCLES   = 60;
    localparam int     TAIL_CYCLES   = 16;
    localparam int     PHASE_WORDS   = 420;
    localparam longint MS_PER_DAY    = 64'sd86400000;
    localparam longint MS_PER_HOUR   = 64'sd3600000;
    localparam longint MS_PER_MINUTE = 64'sd60000;

    typedef struct {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic signed [5:0]  hour;
        logic [5:0]         minute;
        logic [15:0]        second_ms;
        logic signed [5:0]  zone_hours;
    } date_word_t;

    typedef struct {
        logic               ok;
        logic signed [50:0] ms;
        logic signed [41:0] secs;
    } epoch_word_t;

    typedef enum int { WANT_PREDICTED, WANT_VALID, WANT_INVALID } want_kind_t;

    typedef struct {
        date_word_t  word;
        want_kind_t  kind;
        epoch_word_t want;
    } date_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               date_valid = 1'b0;
    logic               date_stall;
    logic signed [15:0] year = '0;
    logic [3:0]         month = '0;
    logic [4:0]         day = '0;
    logic signed [5:0]  hour = '0;
    logic [5:0]         minute = '0;
    logic [15:0]        second_ms = '0;
    logic signed [5:0]  zone_hours = '0;
    logic               epoch_valid;
    logic               epoch_stall = 1'b0;
    logic               valid_res;
    logic signed [50:0] epoch_ms;
    logic signed [41:0] epoch_seconds;

    epoch_word_t utc_next;
    epoch_word_t utc_due[$];
    epoch_word_t utc_got;
    date_row_t   date_rows[$];

    int mismatches = 0;
    int words_sent = 0;
    int results_seen = 0;
    int invalid_seen = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    datetime_to_epoch_ms_unit uut (.*);

    always #CLK_HALF clk = ~clk;

    function automatic longint month_days(input longint y, input longint m);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            2:          return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    // days-from-civil over 400-year eras, then the time of day on top
    function automatic epoch_word_t utc_ms_of(input date_word_t w);
        longint      y, mo, dd, hr, yy, era, yoe, mp, doy, doe, days, ms, secs;
        epoch_word_t r;
        y  = w.year;
        mo = w.month;
        dd = w.day;
        hr = w.hour;
        r.ok = 1'b0;
        r.ms = '0;
        r.secs = '0;
        if (mo < 1) mo = 1;
        if (dd < 1) dd = 1;
        if (hr < 0) hr = 0;
        if (y < -32767 || mo > dte_pkg::MONTH_MAX || dd > month_days(y, mo))
            return r;
        yy   = (mo <= 2) ? y - 1 : y;
        era  = ((yy >= 0) ? yy : yy - 399) / 400;
        yoe  = yy - era * 400;
        mp   = (mo > 2) ? mo - 3 : mo + 9;
        doy  = (153 * mp + 2) / 5 + dd - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = era * 146097 + doe - 719468;
        ms   = days * MS_PER_DAY + (hr - longint'(w.zone_hours)) * MS_PER_HOUR
             + longint'(w.minute) * MS_PER_MINUTE + longint'(w.second_ms);
        secs = ms / 1000;
        r.ok = 1'b1;
        r.ms = ms[50:0];
        r.secs = secs[41:0];
        return r;
    endfunction

    function automatic date_row_t row(input int y, input int mo, input int d, input int h,
                                      input int mi, input int s, input int z,
                                      input want_kind_t kind, input longint ms = 0,
                                      input longint secs = 0);
        date_row_t r;
        r.word.year = 16'(y);
        r.word.month = 4'(mo);
        r.word.day = 5'(d);
        r.word.hour = 6'(h);
        r.word.minute = 6'(mi);
        r.word.second_ms = 16'(s);
        r.word.zone_hours = 6'(z);
        r.kind = kind;
        r.want.ok = (kind == WANT_VALID);
        r.want.ms = 51'(ms);
        r.want.secs = 42'(secs);
        return r;
    endfunction

    // mostly well-formed dates, some deliberately broken, the rest raw bits
    function automatic date_word_t random_date();
        int         pick, y, mo, mlen;
        date_word_t w;
        pick = int'($urandom_range(99));
        if (pick < 15)
        begin
            w.year = 16'($urandom);
            w.month = 4'($urandom);
            w.day = 5'($urandom);
            w.hour = 6'($urandom);
            w.minute = 6'($urandom);
            w.second_ms = 16'($urandom);
            w.zone_hours = 6'($urandom);
            return w;
        end
        if ($urandom_range(3) == 0)
            y = int'($urandom_range(2400, 1600));
        else
            y = int'($urandom_range(65534)) - 32767;
        mo = int'($urandom_range(12, 1));
        mlen = int'(month_days(y, mo));
        w.year = 16'(y);
        w.month = 4'(mo);
        w.day = 5'($urandom_range(mlen, 1));
        w.hour = 6'(int'($urandom_range(24)) - 1);
        w.minute = 6'($urandom_range(59));
        w.second_ms = 16'($urandom_range(59999));
        w.zone_hours = 6'(int'($urandom_range(46)) - 23);
        if (pick < 30)
        begin
            case ($urandom_range(3))
                0: w.month = 4'($urandom_range(15, 13));
                1:
                begin
                    if (mlen == 31) mo = 2;
                    w.month = 4'(mo);
                    w.day = 5'($urandom_range(31, int'(month_days(y, mo)) + 1));
                end
                2: w.year = 16'(-32768);
                default:
                begin
                    if ($urandom_range(1) != 0) w.month = 4'd0;
                    w.day = ($urandom_range(1) != 0) ? 5'd0 : w.day;
                end
            endcase
        end
        return w;
    endfunction

    task automatic send_word(input date_word_t w, input epoch_word_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            date_valid <= 1'b0;
            @(posedge clk);
        end
        date_valid <= 1'b1;
        year <= w.year;
        month <= w.month;
        day <= w.day;
        hour <= w.hour;
        minute <= w.minute;
        second_ms <= w.second_ms;
        zone_hours <= w.zone_hours;
        utc_next <= want;
        @(posedge clk);
        while (date_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        date_valid <= 1'b0;
        @(posedge clk);
        while (utc_due.size() != 0) @(posedge clk);
    endtask

    // expectation travels with the word so it lands in order at acceptance
    always @(posedge clk)
    begin
        if (rst_n && date_valid && !date_stall)
        begin
            utc_due.push_back(utc_next);
            words_sent++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (epoch_valid && !epoch_stall)
            begin
                results_seen++;
                if (!valid_res) invalid_seen++;
                if (utc_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with none expected, actual ok %0b ms %0d s %0d",
                             $time, valid_res, epoch_ms, epoch_seconds);
                end
                else
                begin
                    utc_got = utc_due.pop_front();
                    if (valid_res !== utc_got.ok)
                    begin
                        mismatches++;
                        $display("%0t: valid_res expected %0b, actual %0b",
                                 $time, utc_got.ok, valid_res);
                    end
                    if (epoch_ms !== utc_got.ms)
                    begin
                        mismatches++;
                        $display("%0t: epoch_ms expected %0d, actual %0d",
                                 $time, utc_got.ms, epoch_ms);
                    end
                    if (epoch_seconds !== utc_got.secs)
                    begin
                        mismatches++;
                        $display("%0t: epoch_seconds expected %0d, actual %0d",
                                 $time, utc_got.secs, epoch_seconds);
                    end
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                epoch_stall <= 1'b1;
            end
            else
                epoch_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, utc_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int          send_mix[4];
        int          stall_mix[4];
        date_word_t  w;
        epoch_word_t want;

        send_mix  = '{0, 86, 0, 7};
        stall_mix = '{0, 0, 86, 7};

        date_rows.push_back(row(1970, 1, 1, 0, 0, 0, 0, WANT_VALID, 0, 0));
        // absent month, day and hour read as january first at midnight
        date_rows.push_back(row(1970, 0, 0, -1, 0, 0, 0, WANT_VALID, 0, 0));
        date_rows.push_back(row(1970, 1, 1, 0, 0, 1500, 0, WANT_VALID, 1500, 1));
        // just before the epoch: seconds truncate toward zero
        date_rows.push_back(row(1969, 12, 31, 23, 59, 59500, 0, WANT_VALID, -500, 0));
        date_rows.push_back(row(1970, 1, 1, 0, 0, 0, 1, WANT_VALID, -3600000, -3600));
        date_rows.push_back(row(1970, 1, 2, 0, 0, 0, 0, WANT_VALID, 86400000, 86400));
        date_rows.push_back(row(1970, 13, 1, 0, 0, 0, 0, WANT_INVALID));
        date_rows.push_back(row(1970, 14, 5, 3, 0, 0, 0, WANT_INVALID));
        date_rows.push_back(row(2023, 15, 31, 23, 59, 59999, -23, WANT_INVALID));
        date_rows.push_back(row(2023, 4, 31, 0, 0, 0, 0, WANT_INVALID));
        date_rows.push_back(row(1900, 2, 29, 0, 0, 0, 0, WANT_INVALID));
        date_rows.push_back(row(2100, 2, 29, 0, 0, 0, 0, WANT_INVALID));
        date_rows.push_back(row(1970, 2, 31, 0, 0, 0, 0, WANT_INVALID));
        date_rows.push_back(row(-32768, 1, 1, 0, 0, 0, 0, WANT_INVALID));
        date_rows.push_back(row(2000, 2, 29, 12, 0, 0, 0, WANT_PREDICTED));
        date_rows.push_back(row(2024, 2, 29, 0, 0, 0, 0, WANT_PREDICTED));
        date_rows.push_back(row(32767, 12, 31, 23, 59, 59999, -23, WANT_PREDICTED));
        date_rows.push_back(row(-32767, 1, 1, -1, 0, 0, 23, WANT_PREDICTED));
        // time fields past their range carry into later or earlier days
        date_rows.push_back(row(2023, 6, 15, 31, 63, 65535, -32, WANT_PREDICTED));
        date_rows.push_back(row(2023, 6, 15, -32, 0, 0, 31, WANT_PREDICTED));
        date_rows.push_back(row(0, 2, 29, 0, 0, 0, 0, WANT_PREDICTED));
        date_rows.push_back(row(-1, 3, 1, 12, 30, 30000, 5, WANT_PREDICTED));
        date_rows.push_back(row(1970, 0, 31, 0, 0, 0, 0, WANT_PREDICTED));
        date_rows.push_back(row(1, 1, 1, 0, 0, 0, 0, WANT_PREDICTED));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (date_rows[i])
        begin
            if (date_rows[i].kind == WANT_PREDICTED)
                want = utc_ms_of(date_rows[i].word);
            else
                want = date_rows[i].want;
            send_word(date_rows[i].word, want);
        end
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = send_mix[phase];
            recv_stall_pct <= stall_mix[phase];
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // long output hold while words keep coming, then a full drain
                if (phase == 0 && n == 200) hold_req <= hold_req + 1;
                if (phase == 0 && n == 260) wait_drained();
                w = random_date();
                send_word(w, utc_ms_of(w));
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (utc_due.size() != 0)
        begin
            mismatches += utc_due.size();
            $display("%0t: %0d results never arrived", $time, utc_due.size());
        end

        $display("%0d date words converted, %0d results checked, %0d of them impossible dates",
                 words_sent, results_seen, invalid_seen);
        $display("ran free flow, sparse input, heavy output stall, light mixed idling and a long hold");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/dte_pkg.sv
rtl/core/dte_front.sv
rtl/core/dte_fifo.sv
rtl/core/dte_back.sv
rtl/core/datetime_to_epoch_ms_unit.sv
tb/sv/tb.sv
